// ----- rtl/m4i_pkg.sv -----
// shared types, constant tables and float helper functions for the 4x4 matrix inverse
package m4i_pkg;

    localparam int N_SUB = 19;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_mat;
    typedef logic [N_SUB-1:0][31:0] t_svec;
    typedef logic [3:0][31:0] t_row;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SUB,
        PH_COF,
        PH_DETP
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] k;
        logic [2:0] step;
        logic [1:0] col;
        logic       div_start;
    } t_ctl;

    typedef struct packed {
        logic       we;
        logic [4:0] idx;
        t_word      data;
    } t_swr;

    // matrix element indexes (row * 4 + col) of a*b - c*d for each sub-determinant
    localparam logic [3:0] S_SRC [N_SUB][4] = '{
        '{4'd10, 4'd15, 4'd14, 4'd11},
        '{4'd9,  4'd15, 4'd13, 4'd11},
        '{4'd9,  4'd14, 4'd13, 4'd10},
        '{4'd8,  4'd15, 4'd12, 4'd11},
        '{4'd8,  4'd14, 4'd12, 4'd10},
        '{4'd8,  4'd13, 4'd12, 4'd9},
        '{4'd6,  4'd15, 4'd14, 4'd7},
        '{4'd5,  4'd15, 4'd13, 4'd7},
        '{4'd5,  4'd14, 4'd13, 4'd6},
        '{4'd4,  4'd15, 4'd12, 4'd7},
        '{4'd4,  4'd14, 4'd12, 4'd6},
        '{4'd5,  4'd15, 4'd13, 4'd7},
        '{4'd4,  4'd13, 4'd12, 4'd5},
        '{4'd6,  4'd11, 4'd10, 4'd7},
        '{4'd5,  4'd11, 4'd9,  4'd7},
        '{4'd5,  4'd10, 4'd9,  4'd6},
        '{4'd4,  4'd11, 4'd8,  4'd7},
        '{4'd4,  4'd10, 4'd8,  4'd6},
        '{4'd4,  4'd9,  4'd8,  4'd5}
    };

    // cofactor terms: matrix element and sub-determinant for each of three products
    localparam logic [3:0] COF_M [4][4][3] = '{
        '{'{4'd5, 4'd6, 4'd7}, '{4'd4, 4'd6, 4'd7}, '{4'd4, 4'd5, 4'd7}, '{4'd4, 4'd5, 4'd6}},
        '{'{4'd1, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3}, '{4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd2}},
        '{'{4'd1, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3}, '{4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd2}},
        '{'{4'd1, 4'd2, 4'd3}, '{4'd0, 4'd2, 4'd3}, '{4'd0, 4'd1, 4'd3}, '{4'd0, 4'd1, 4'd2}}
    };

    localparam logic [4:0] COF_S [4][4][3] = '{
        '{'{5'd0,  5'd1,  5'd2},  '{5'd0,  5'd3,  5'd4},
          '{5'd1,  5'd3,  5'd5},  '{5'd2,  5'd4,  5'd5}},
        '{'{5'd0,  5'd1,  5'd2},  '{5'd0,  5'd3,  5'd4},
          '{5'd1,  5'd3,  5'd5},  '{5'd2,  5'd4,  5'd5}},
        '{'{5'd6,  5'd7,  5'd8},  '{5'd6,  5'd9,  5'd10},
          '{5'd11, 5'd9,  5'd12}, '{5'd8,  5'd10, 5'd12}},
        '{'{5'd13, 5'd14, 5'd15}, '{5'd13, 5'd16, 5'd17},
          '{5'd14, 5'd16, 5'd18}, '{5'd15, 5'd17, 5'd18}}
    };

    function automatic logic [5:0] f_lzc48(input logic [47:0] x);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // sig[25] is the leading one, sig[1] guard, sig[0] sticky; e is the biased exponent
    function automatic t_word f_round(input logic sgn, input logic signed [9:0] e,
                                      input logic [25:0] sig);
        logic [9:0]  sh;
        logic [25:0] d;
        logic [25:0] mask;
        logic        lost;
        logic [7:0]  ef;
        logic        inc;
        logic [30:0] mag;
        t_word       res;
        d    = sig;
        ef   = e[7:0];
        sh   = '0;
        mask = '0;
        lost = 1'b0;
        if (e <= 10'sd0) begin
            ef = 8'd0;
            sh = 10'd1 - $unsigned(e);
            if (sh >= 10'd26) begin
                d = {25'd0, |sig};
            end else begin
                mask = (26'd1 << sh) - 26'd1;
                lost = |(sig & mask);
                d    = sig >> sh;
                d[0] = d[0] | lost;
            end
        end
        inc = d[1] & (d[0] | d[2]);
        mag = {ef, d[24:2]} + {30'd0, inc};
        if (e > 10'sd254) begin
            res = {sgn, 8'hFF, 23'd0};
        end else begin
            res = {sgn, mag};
        end
        return res;
    endfunction

    function automatic t_word f_canon(input t_word w);
        return ((w[30:23] == 8'hFF) && (|w[22:0])) ? CANON_NAN : w;
    endfunction

endpackage

// ----- rtl/m4i_mul.sv -----
// binary32 multiplier, round to nearest even
module m4i_mul (
    input  m4i_pkg::t_word i_a,
    input  m4i_pkg::t_word i_b,
    output m4i_pkg::t_word o_y
);
    import m4i_pkg::*;

    logic               s;
    logic [7:0]         ea, eb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]        ma, mb;
    logic signed [9:0]  xa, xb, e;
    logic [47:0]        p, pn;
    logic [5:0]         lz;
    logic [25:0]        sig;

    always_comb begin
        s      = i_a[31] ^ i_b[31];
        ea     = i_a[30:23];
        eb     = i_b[30:23];
        a_nan  = (&ea) && (|i_a[22:0]);
        b_nan  = (&eb) && (|i_b[22:0]);
        a_inf  = (&ea) && !(|i_a[22:0]);
        b_inf  = (&eb) && !(|i_b[22:0]);
        a_zero = !(|i_a[30:0]);
        b_zero = !(|i_b[30:0]);
        ma     = {|ea, i_a[22:0]};
        mb     = {|eb, i_b[22:0]};
        xa     = (|ea) ? $signed({2'b0, ea}) : 10'sd1;
        xb     = (|eb) ? $signed({2'b0, eb}) : 10'sd1;
        p      = ma * mb;
        lz     = f_lzc48(p);
        pn     = p << lz;
        sig    = {pn[47:23], |pn[22:0]};
        e      = xa + xb - 10'sd126 - $signed({4'd0, lz});
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            o_y = CANON_NAN;
        end else if (a_inf || b_inf) begin
            o_y = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            o_y = {s, 31'd0};
        end else begin
            o_y = f_round(s, e, sig);
        end
    end

endmodule

// ----- rtl/m4i_add.sv -----
// binary32 adder and subtractor, round to nearest even
module m4i_add (
    input  m4i_pkg::t_word i_a,
    input  m4i_pkg::t_word i_b,
    input  logic           i_sub,
    output m4i_pkg::t_word o_y
);
    import m4i_pkg::*;

    t_word              b_eff, big, sml;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]         e_big, e_sml, d;
    logic [23:0]        m_big, m_sml;
    logic [26:0]        x, y0, y, mask;
    logic [27:0]        z, zn;
    logic [5:0]         lz;
    logic [25:0]        sig;
    logic signed [9:0]  e;

    always_comb begin
        b_eff  = {i_b[31] ^ i_sub, i_b[30:0]};
        a_nan  = (&i_a[30:23]) && (|i_a[22:0]);
        b_nan  = (&i_b[30:23]) && (|i_b[22:0]);
        a_inf  = (&i_a[30:23]) && !(|i_a[22:0]);
        b_inf  = (&i_b[30:23]) && !(|i_b[22:0]);
        a_zero = !(|i_a[30:0]);
        b_zero = !(|i_b[30:0]);
        if (b_eff[30:0] > i_a[30:0]) begin
            big = b_eff;
            sml = i_a;
        end else begin
            big = i_a;
            sml = b_eff;
        end
        e_big = (|big[30:23]) ? big[30:23] : 8'd1;
        e_sml = (|sml[30:23]) ? sml[30:23] : 8'd1;
        m_big = {|big[30:23], big[22:0]};
        m_sml = {|sml[30:23], sml[22:0]};
        d     = e_big - e_sml;
        x     = {m_big, 3'b000};
        y0    = {m_sml, 3'b000};
        mask  = '0;
        if (d >= 8'd27) begin
            y = {26'd0, |y0};
        end else begin
            mask = (27'd1 << d) - 27'd1;
            y    = y0 >> d;
            y[0] = y[0] | (|(y0 & mask));
        end
        if (big[31] == sml[31]) begin
            z = {1'b0, x} + {1'b0, y};
        end else begin
            z = {1'b0, x} - {1'b0, y};
        end
        lz  = f_lzc48({z, 20'd0});
        zn  = z << lz;
        sig = {zn[27:3], |zn[2:0]};
        e   = $signed({2'b0, e_big}) + 10'sd1 - $signed({4'd0, lz});
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[31] != b_eff[31]))) begin
            o_y = CANON_NAN;
        end else if (a_inf) begin
            o_y = i_a;
        end else if (b_inf) begin
            o_y = b_eff;
        end else if (a_zero && b_zero) begin
            o_y = {i_a[31] & b_eff[31], 31'd0};
        end else if (a_zero) begin
            o_y = b_eff;
        end else if (b_zero) begin
            o_y = i_a;
        end else if (z == 28'd0) begin
            o_y = 32'd0;
        end else begin
            o_y = f_round(big[31], e, sig);
        end
    end

endmodule

// ----- rtl/m4i_div.sv -----
// binary32 divider, restoring, one quotient bit per cycle
module m4i_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  m4i_pkg::t_word i_a,
    input  m4i_pkg::t_word i_b,
    output logic           o_done,
    output m4i_pkg::t_word o_q
);
    import m4i_pkg::*;

    localparam int DIV_STEPS = 27;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    t_word              r_q, n_q;
    logic [4:0]         r_cnt, n_cnt;
    logic [24:0]        r_rem, n_rem;
    logic [26:0]        r_quo, n_quo;
    logic [23:0]        r_den, n_den;
    logic signed [9:0]  r_exp, n_exp;
    logic               r_sgn, n_sgn;

    logic               s;
    logic [7:0]         ea, eb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0]        ma, mb, nx, ny;
    logic [5:0]         lzx, lzy;
    logic signed [9:0]  xa, xb, e;
    logic               ge;
    logic [24:0]        diff;
    logic [26:0]        qn;
    logic [25:0]        sig;

    always_comb begin
        s      = i_a[31] ^ i_b[31];
        ea     = i_a[30:23];
        eb     = i_b[30:23];
        a_nan  = (&ea) && (|i_a[22:0]);
        b_nan  = (&eb) && (|i_b[22:0]);
        a_inf  = (&ea) && !(|i_a[22:0]);
        b_inf  = (&eb) && !(|i_b[22:0]);
        a_zero = !(|i_a[30:0]);
        b_zero = !(|i_b[30:0]);
        ma     = {|ea, i_a[22:0]};
        mb     = {|eb, i_b[22:0]};
        lzx    = f_lzc48({ma, 24'd0});
        lzy    = f_lzc48({mb, 24'd0});
        nx     = ma << lzx;
        ny     = mb << lzy;
        xa     = (|ea) ? $signed({2'b0, ea}) : 10'sd1;
        xb     = (|eb) ? $signed({2'b0, eb}) : 10'sd1;
        ge     = r_rem >= {1'b0, r_den};
        diff   = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        qn     = {r_quo[25:0], ge};
        if (qn[26]) begin
            sig = {qn[26:2], (|qn[1:0]) | (|diff)};
            e   = r_exp;
        end else begin
            sig = {qn[25:1], qn[0] | (|diff)};
            e   = r_exp - 10'sd1;
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_exp  = r_exp;
        n_sgn  = r_sgn;
        if (i_start) begin
            n_sgn = s;
            if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                n_q    = CANON_NAN;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (a_inf || b_zero) begin
                n_q    = {s, 8'hFF, 23'd0};
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (a_zero || b_inf) begin
                n_q    = {s, 31'd0};
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_rem  = {1'b0, nx};
                n_den  = ny;
                n_quo  = '0;
                n_exp  = xa - xb - $signed({4'd0, lzx}) + $signed({4'd0, lzy}) + 10'sd127;
            end
        end else if (r_busy) begin
            n_quo = qn;
            n_rem = {diff[23:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_q    = f_round(r_sgn, e, sig);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_exp <= n_exp;
        r_sgn <= n_sgn;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ----- rtl/m4i_lane.sv -----
// one lane: sub-determinants, one row of cofactors, one determinant product and its four divides
module m4i_lane #(
    parameter int LANE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  m4i_pkg::t_ctl   i_ctl,
    input  m4i_pkg::t_mat   i_mat,
    input  m4i_pkg::t_svec  i_s,
    input  m4i_pkg::t_word  i_det,
    output m4i_pkg::t_swr   o_swr,
    output m4i_pkg::t_word  o_prod,
    output m4i_pkg::t_row   o_row,
    output logic            o_done
);
    import m4i_pkg::*;

    localparam logic [1:0] LN = 2'(LANE);

    t_word       r_t0, n_t0;
    t_word       r_t1, n_t1;
    t_row        r_inv, n_inv;
    logic [1:0]  r_dcol, n_dcol;
    logic        r_done, n_done;

    t_word       mul_a, mul_b, mul_y;
    t_word       add_a, add_b, add_y;
    logic        add_sub;
    logic        div_start, div_done;
    t_word       div_a, div_q;
    logic [4:0]  j, jj;
    logic        pos;
    t_swr        swr;

    always_comb begin
        j       = {i_ctl.k, LN};
        jj      = (j < 5'(N_SUB)) ? j : 5'd0;
        pos     = !(LN[0] ^ i_ctl.col[0]);
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_inv   = r_inv;
        n_dcol  = r_dcol;
        n_done  = r_done;
        mul_a   = r_t0;
        mul_b   = r_t1;
        add_a   = r_t0;
        add_b   = r_t1;
        add_sub = 1'b0;
        swr     = '0;
        case (i_ctl.phase)
            PH_SUB: begin
                case (i_ctl.step)
                    3'd0: begin
                        mul_a = i_mat[S_SRC[jj][0]];
                        mul_b = i_mat[S_SRC[jj][1]];
                        n_t0  = mul_y;
                    end
                    3'd1: begin
                        mul_a = i_mat[S_SRC[jj][2]];
                        mul_b = i_mat[S_SRC[jj][3]];
                        n_t1  = mul_y;
                    end
                    3'd2: begin
                        add_sub  = 1'b1;
                        swr.we   = (j < 5'(N_SUB));
                        swr.idx  = j;
                        swr.data = add_y;
                    end
                    default: ;
                endcase
            end
            PH_COF: begin
                case (i_ctl.step)
                    3'd0: begin
                        mul_a = i_mat[COF_M[LN][i_ctl.col][0]] ^ {!pos, 31'd0};
                        mul_b = i_s[COF_S[LN][i_ctl.col][0]];
                        n_t0  = mul_y;
                    end
                    3'd1: begin
                        mul_a = i_mat[COF_M[LN][i_ctl.col][1]];
                        mul_b = i_s[COF_S[LN][i_ctl.col][1]];
                        n_t1  = mul_y;
                    end
                    3'd2: begin
                        add_sub = pos;
                        n_t0    = add_y;
                    end
                    3'd3: begin
                        mul_a = i_mat[COF_M[LN][i_ctl.col][2]];
                        mul_b = i_s[COF_S[LN][i_ctl.col][2]];
                        n_t1  = mul_y;
                    end
                    3'd4: begin
                        add_sub            = !pos;
                        n_inv[i_ctl.col]   = add_y;
                    end
                    default: ;
                endcase
            end
            PH_DETP: begin
                mul_a = i_mat[4'(LANE)];
                mul_b = r_inv[0];
                n_t0  = mul_y;
            end
            default: ;
        endcase

        div_start = 1'b0;
        div_a     = r_inv[0];
        if (i_ctl.div_start) begin
            div_start = 1'b1;
            n_dcol    = 2'd0;
            n_done    = 1'b0;
        end else if (div_done) begin
            n_inv[r_dcol] = div_q;
            n_dcol        = r_dcol + 2'd1;
            if (r_dcol == 2'd3) begin
                n_done = 1'b1;
            end else begin
                div_start = 1'b1;
                div_a     = r_inv[r_dcol + 2'd1];
            end
        end
    end

    m4i_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_y (mul_y)
    );

    m4i_add u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_sub (add_sub),
        .o_y   (add_y)
    );

    m4i_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (i_det),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcol <= '0;
            r_done <= 1'b0;
        end else begin
            r_dcol <= n_dcol;
            r_done <= n_done;
        end
        r_t0  <= n_t0;
        r_t1  <= n_t1;
        r_inv <= n_inv;
    end

    assign o_swr  = swr;
    assign o_prod = r_t0;
    assign o_row  = r_inv;
    assign o_done = r_done;

endmodule

// ----- rtl/matrix4_inverse_float.sv -----
// 4x4 binary32 matrix inverse by cofactors: four row requests in, four inverse rows out.
// Each request loads one matrix row, one request per cycle while o_ready is high. After the fourth,
// four lanes form the 19 sub-determinants and one cofactor row each, the determinant is merged
// from the four lane products, then each lane divides its row by the determinant with a
// bit-serial divider, one element after another. The divides take most of the time from the
// first loaded row to the last result.
// Results leave in row order; singular is set on all four when the determinant is zero.
module matrix4_inverse_float (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_comp_x,
    input  logic [31:0]         i_comp_y,
    input  logic [31:0]         i_comp_z,
    input  logic [31:0]         i_comp_w,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_vec_index,
    output logic [31:0]         o_out_x,
    output logic [31:0]         o_out_y,
    output logic [31:0]         o_out_z,
    output logic [31:0]         o_out_w,
    output logic                o_singular,
    output logic                o_last_out
);
    import m4i_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SUB,
        S_COF,
        S_DETP,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_lc, n_lc;
    t_mat        r_mat, n_mat;
    t_svec       r_s;
    logic [2:0]  r_k, n_k;
    logic [2:0]  r_step, n_step;
    logic [1:0]  r_col, n_col;
    logic [1:0]  r_sum_i, n_sum_i;
    t_word       r_det, n_det;
    logic [1:0]  r_row, n_row;
    logic        r_dstart, n_dstart;

    t_ctl        ctl;
    t_swr        w_swr [4];
    t_word       w_prod [4];
    t_row        w_row [4];
    logic [3:0]  w_done;
    t_word       sum_a, sum_y;

    always_comb begin
        ctl           = '0;
        ctl.k         = r_k;
        ctl.step      = r_step;
        ctl.col       = r_col;
        ctl.div_start = r_dstart;
        case (r_state)
            S_SUB:   ctl.phase = PH_SUB;
            S_COF:   ctl.phase = PH_COF;
            S_DETP:  ctl.phase = PH_DETP;
            default: ctl.phase = PH_IDLE;
        endcase
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        m4i_lane #(.LANE(l)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_mat   (r_mat),
            .i_s     (r_s),
            .i_det   (r_det),
            .o_swr   (w_swr[l]),
            .o_prod  (w_prod[l]),
            .o_row   (w_row[l]),
            .o_done  (w_done[l])
        );
    end

    assign sum_a = (r_sum_i == 2'd0) ? w_prod[0] : r_det;

    m4i_add u_sum (
        .i_a   (sum_a),
        .i_b   (w_prod[r_sum_i + 2'd1]),
        .i_sub (1'b0),
        .o_y   (sum_y)
    );

    always_comb begin
        n_state  = r_state;
        n_lc     = r_lc;
        n_mat    = r_mat;
        n_k      = r_k;
        n_step   = r_step;
        n_col    = r_col;
        n_sum_i  = r_sum_i;
        n_det    = r_det;
        n_row    = r_row;
        n_dstart = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    n_mat[{r_lc, 2'd0}] = i_comp_x;
                    n_mat[{r_lc, 2'd1}] = i_comp_y;
                    n_mat[{r_lc, 2'd2}] = i_comp_z;
                    n_mat[{r_lc, 2'd3}] = i_comp_w;
                    n_lc                = r_lc + 2'd1;
                    if (r_lc == 2'd3) begin
                        n_state = S_SUB;
                        n_k     = '0;
                        n_step  = '0;
                    end
                end
            end
            S_SUB: begin
                if (r_step == 3'd2) begin
                    n_step = '0;
                    if (r_k == 3'd4) begin
                        n_state = S_COF;
                        n_col   = '0;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_COF: begin
                if (r_step == 3'd4) begin
                    n_step = '0;
                    if (r_col == 2'd3) begin
                        n_state = S_DETP;
                    end else begin
                        n_col = r_col + 2'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_DETP: begin
                n_state = S_SUM;
                n_sum_i = '0;
            end
            S_SUM: begin
                n_det   = sum_y;
                n_sum_i = r_sum_i + 2'd1;
                if (r_sum_i == 2'd2) begin
                    n_state  = S_DIV;
                    n_dstart = 1'b1;
                end
            end
            S_DIV: begin
                if (!r_dstart && (&w_done)) begin
                    n_state = S_OUT;
                    n_row   = '0;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_row = r_row + 2'd1;
                    if (r_row == 2'd3) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_lc     <= '0;
            r_k      <= '0;
            r_step   <= '0;
            r_col    <= '0;
            r_sum_i  <= '0;
            r_row    <= '0;
            r_dstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lc     <= n_lc;
            r_k      <= n_k;
            r_step   <= n_step;
            r_col    <= n_col;
            r_sum_i  <= n_sum_i;
            r_row    <= n_row;
            r_dstart <= n_dstart;
        end
        r_mat <= n_mat;
        r_det <= n_det;
        for (int l = 0; l < 4; l++) begin
            if (w_swr[l].we) begin
                r_s[w_swr[l].idx] <= w_swr[l].data;
            end
        end
    end

    assign o_ready     = (r_state == S_LOAD);
    assign o_valid     = (r_state == S_OUT);
    assign o_vec_index = r_row;
    assign o_out_x     = f_canon(w_row[r_row][0]);
    assign o_out_y     = f_canon(w_row[r_row][1]);
    assign o_out_z     = f_canon(w_row[r_row][2]);
    assign o_out_w     = f_canon(w_row[r_row][3]);
    assign o_singular  = (r_det[30:0] == 31'd0);
    assign o_last_out  = (r_row == 2'd3);

endmodule

// ----- sim/matrix4_inverse_float_checker.sv -----
// request/result monitor for matrix4_inverse_float: binary32 inverse predictor and compare
module matrix4_inverse_float_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_comp_x,
    input  logic [31:0] i_comp_y,
    input  logic [31:0] i_comp_z,
    input  logic [31:0] i_comp_w,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_vec_index,
    input  logic [31:0] i_out_x,
    input  logic [31:0] i_out_y,
    input  logic [31:0] i_out_z,
    input  logic [31:0] i_out_w,
    input  logic        i_singular,
    input  logic        i_last_out,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef struct {
        logic [1:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        sing;
        logic        last;
    } t_inv_row;

    logic [31:0] rows_held [16];
    logic [1:0]  rows_loaded;
    t_inv_row    inv_rows_due [$];
    int          errors = 0;

    assign o_errors  = errors;
    assign o_pending = inv_rows_due.size();

    function automatic bit is_nan(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 0);
    endfunction

    function automatic bit is_inf(logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 0);
    endfunction

    function automatic bit is_zero(logic [31:0] a);
        return a[30:0] == 0;
    endfunction

    function automatic void fp_split(input logic [31:0] a, output longint unsigned m,
                                     output int e);
        if (a[30:23] == 0) begin
            m = a[22:0];
            e = -149;
        end else begin
            m = {1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    // value is m * 2^e, rounded to nearest even
    function automatic logic [31:0] fp_pack(bit s, longint unsigned m, int e);
        int              p;
        int              q;
        int              sh;
        longint unsigned r;
        bit              g;
        bit              st;
        if (m == 0) return {s, 31'd0};
        p = 63;
        while (!m[p]) p--;
        q = p + e - 23;
        if (q < -149) q = -149;
        sh = q - e;
        if (sh <= 0) begin
            r = m << (-sh);
            g = 0;
            st = 0;
        end else if (sh > 64) begin
            r = 0;
            g = 0;
            st = 1;
        end else begin
            r = (sh == 64) ? 0 : (m >> sh);
            g = m[sh-1];
            st = (sh > 1) ? ((m << (65 - sh)) != 0) : 1'b0;
        end
        if (g && (st || r[0])) r++;
        if (r == (64'd1 << 24)) begin
            r = 64'd1 << 23;
            q++;
        end
        if (r < (64'd1 << 23)) return {s, 8'd0, r[22:0]};
        if (q + 150 >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(q + 150), r[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        longint unsigned ma;
        longint unsigned mb;
        int              ea;
        int              eb;
        bit              s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return QNAN;
            return {s, 8'hFF, 23'd0};
        end
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        return fp_pack(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned big;
        longint unsigned tiny;
        longint unsigned m;
        int              ea;
        int              eb;
        int              e;
        bit              sa;
        bit              sb;
        bit              s;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
        if (is_zero(a)) return b;
        if (is_zero(b)) return a;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        sa = a[31];
        sb = b[31];
        if (ea < eb) begin
            {ma, mb} = {mb, ma};
            {ea, eb} = {eb, ea};
            {sa, sb} = {sb, sa};
        end
        if (ea - eb <= 38) begin
            big = ma << (ea - eb);
            tiny = mb;
            e = eb;
        end else begin
            // far smaller operand only acts as sticky
            big = ma << 3;
            tiny = 1;
            e = ea - 3;
        end
        if (sa == sb) begin
            m = big + tiny;
            s = sa;
        end else if (big >= tiny) begin
            m = big - tiny;
            s = sa;
        end else begin
            m = tiny - big;
            s = sb;
        end
        if (m == 0) return 32'd0;
        return fp_pack(s, m, e);
    endfunction

    function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
        return fp_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic [31:0] fp_div(logic [31:0] x, logic [31:0] d);
        longint unsigned mx;
        longint unsigned md;
        longint unsigned quo;
        longint unsigned rem;
        int              ex;
        int              ed;
        bit              s;
        s = x[31] ^ d[31];
        if (is_zero(d)) begin
            if (is_zero(x) || is_nan(x)) return QNAN;
            return {s, 8'hFF, 23'd0};
        end
        if (is_nan(x) || is_nan(d)) return QNAN;
        if (is_inf(x)) return is_inf(d) ? QNAN : {s, 8'hFF, 23'd0};
        if (is_inf(d) || is_zero(x)) return {s, 31'd0};
        fp_split(x, mx, ex);
        fp_split(d, md, ed);
        while (!mx[23]) begin
            mx = mx << 1;
            ex--;
        end
        while (!md[23]) begin
            md = md << 1;
            ed--;
        end
        quo = (mx << 40) / md;
        rem = (mx << 40) % md;
        return fp_pack(s, (quo << 1) | (rem != 0), ex - ed - 41);
    endfunction

    function automatic logic [31:0] minor2(logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
        return fp_sub(fp_mul(a, b), fp_mul(c, d));
    endfunction

    function automatic logic [31:0] cof_plus(logic [31:0] a, logic [31:0] x,
                                             logic [31:0] b, logic [31:0] y,
                                             logic [31:0] c, logic [31:0] z);
        return fp_add(fp_sub(fp_mul(a, x), fp_mul(b, y)), fp_mul(c, z));
    endfunction

    function automatic logic [31:0] cof_minus(logic [31:0] a, logic [31:0] x,
                                              logic [31:0] b, logic [31:0] y,
                                              logic [31:0] c, logic [31:0] z);
        return fp_sub(fp_add(fp_mul({~a[31], a[30:0]}, x), fp_mul(b, y)), fp_mul(c, z));
    endfunction

    task automatic predict_inverse();
        logic [31:0] m [16];
        logic [31:0] s [19];
        logic [31:0] c [4][4];
        logic [31:0] det;
        t_inv_row    row;
        m = rows_held;
        s[0]  = minor2(m[10], m[15], m[14], m[11]);
        s[1]  = minor2(m[9],  m[15], m[13], m[11]);
        s[2]  = minor2(m[9],  m[14], m[13], m[10]);
        s[3]  = minor2(m[8],  m[15], m[12], m[11]);
        s[4]  = minor2(m[8],  m[14], m[12], m[10]);
        s[5]  = minor2(m[8],  m[13], m[12], m[9]);
        s[6]  = minor2(m[6],  m[15], m[14], m[7]);
        s[7]  = minor2(m[5],  m[15], m[13], m[7]);
        s[8]  = minor2(m[5],  m[14], m[13], m[6]);
        s[9]  = minor2(m[4],  m[15], m[12], m[7]);
        s[10] = minor2(m[4],  m[14], m[12], m[6]);
        s[11] = s[7];
        s[12] = minor2(m[4],  m[13], m[12], m[5]);
        s[13] = minor2(m[6],  m[11], m[10], m[7]);
        s[14] = minor2(m[5],  m[11], m[9],  m[7]);
        s[15] = minor2(m[5],  m[10], m[9],  m[6]);
        s[16] = minor2(m[4],  m[11], m[8],  m[7]);
        s[17] = minor2(m[4],  m[10], m[8],  m[6]);
        s[18] = minor2(m[4],  m[9],  m[8],  m[5]);

        c[0][0] = cof_plus (m[5], s[0],  m[6], s[1],  m[7], s[2]);
        c[0][1] = cof_minus(m[4], s[0],  m[6], s[3],  m[7], s[4]);
        c[0][2] = cof_plus (m[4], s[1],  m[5], s[3],  m[7], s[5]);
        c[0][3] = cof_minus(m[4], s[2],  m[5], s[4],  m[6], s[5]);
        c[1][0] = cof_minus(m[1], s[0],  m[2], s[1],  m[3], s[2]);
        c[1][1] = cof_plus (m[0], s[0],  m[2], s[3],  m[3], s[4]);
        c[1][2] = cof_minus(m[0], s[1],  m[1], s[3],  m[3], s[5]);
        c[1][3] = cof_plus (m[0], s[2],  m[1], s[4],  m[2], s[5]);
        c[2][0] = cof_plus (m[1], s[6],  m[2], s[7],  m[3], s[8]);
        c[2][1] = cof_minus(m[0], s[6],  m[2], s[9],  m[3], s[10]);
        c[2][2] = cof_plus (m[0], s[11], m[1], s[9],  m[3], s[12]);
        c[2][3] = cof_minus(m[0], s[8],  m[1], s[10], m[2], s[12]);
        c[3][0] = cof_minus(m[1], s[13], m[2], s[14], m[3], s[15]);
        c[3][1] = cof_plus (m[0], s[13], m[2], s[16], m[3], s[17]);
        c[3][2] = cof_minus(m[0], s[14], m[1], s[16], m[3], s[18]);
        c[3][3] = cof_plus (m[0], s[15], m[1], s[17], m[2], s[18]);

        det = fp_add(fp_add(fp_add(fp_mul(m[0], c[0][0]), fp_mul(m[1], c[1][0])),
                            fp_mul(m[2], c[2][0])),
                     fp_mul(m[3], c[3][0]));
        for (int r = 0; r < 4; r++) begin
            row.idx  = 2'(r);
            row.x    = fp_div(c[r][0], det);
            row.y    = fp_div(c[r][1], det);
            row.z    = fp_div(c[r][2], det);
            row.w    = fp_div(c[r][3], det);
            row.sing = is_zero(det);
            row.last = (r == 3);
            inv_rows_due.push_back(row);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_inv_row want;
        if (!i_rst_n) begin
            rows_loaded <= 2'd0;
            inv_rows_due.delete();
        end else begin
            if (i_valid && i_ready_in) begin
                rows_held[{rows_loaded, 2'd0}] = i_comp_x;
                rows_held[{rows_loaded, 2'd1}] = i_comp_y;
                rows_held[{rows_loaded, 2'd2}] = i_comp_z;
                rows_held[{rows_loaded, 2'd3}] = i_comp_w;
                if (rows_loaded == 2'd3) predict_inverse();
                rows_loaded <= rows_loaded + 2'd1;
            end
            if (i_out_valid && i_out_ready) begin
                if (inv_rows_due.size() == 0) begin
                    report("unexpected result", {30'd0, i_vec_index}, 32'd0);
                end else begin
                    want = inv_rows_due.pop_front();
                    if (i_vec_index != want.idx) begin
                        report("vec_index", {30'd0, i_vec_index}, {30'd0, want.idx});
                    end
                    if (i_out_x !== want.x) report("out_x", i_out_x, want.x);
                    if (i_out_y !== want.y) report("out_y", i_out_y, want.y);
                    if (i_out_z !== want.z) report("out_z", i_out_z, want.z);
                    if (i_out_w !== want.w) report("out_w", i_out_w, want.w);
                    if (i_singular !== want.sing) begin
                        report("singular", {31'd0, i_singular}, {31'd0, want.sing});
                    end
                    if (i_last_out !== want.last) begin
                        report("last_out", {31'd0, i_last_out}, {31'd0, want.last});
                    end
                end
            end
        end
    end

endmodule

// ----- sim/matrix4_inverse_float_tb.sv -----
// testbench top for matrix4_inverse_float: matrix row stimulus, flow control and verdict
module matrix4_inverse_float_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_comp_x = '0;
    logic [31:0] i_comp_y = '0;
    logic [31:0] i_comp_z = '0;
    logic [31:0] i_comp_w = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_vec_index;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic [31:0] o_out_w;
    logic        o_singular;
    logic        o_last_out;

    int errors;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    matrix4_inverse_float DUT (.*);

    matrix4_inverse_float_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ready_in  (o_ready),
        .i_comp_x    (i_comp_x),
        .i_comp_y    (i_comp_y),
        .i_comp_z    (i_comp_z),
        .i_comp_w    (i_comp_w),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_vec_index (o_vec_index),
        .i_out_x     (o_out_x),
        .i_out_y     (o_out_y),
        .i_out_z     (o_out_z),
        .i_out_w     (o_out_w),
        .i_singular  (o_singular),
        .i_last_out  (o_last_out),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** matrix4_inverse_float: FAILED **");
            $finish;
        end
    end

    task automatic send_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_comp_x = x;
        i_comp_y = y;
        i_comp_z = z;
        i_comp_w = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_matrix(logic [31:0] m [16]);
        for (int r = 0; r < 4; r++) send_row(m[r*4], m[r*4+1], m[r*4+2], m[r*4+3]);
    endtask

    function automatic logic [31:0] pick_word(int kind);
        logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                       32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                       32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                                       32'h0080_0000};
        int r;
        r = $urandom_range(99);
        case (kind)
            0: begin
                if (r < 70) return {1'($urandom), 8'($urandom_range(134, 120)),
                                    23'($urandom)};
                if (r < 85) return {1'($urandom), 8'($urandom_range(2, 0)) + 8'd127,
                                    23'd0};
                if (r < 93) return $urandom;
                if (r < 97) return specials[$urandom_range(9)];
                return 32'h0000_0000;
            end
            1: return $urandom;
            default: return specials[$urandom_range(9)];
        endcase
    endfunction

    task automatic random_matrix();
        logic [31:0] m [16];
        int          kind;
        int          r;
        r = $urandom_range(99);
        kind = (r < 85) ? 0 : (r < 95) ? 1 : 2;
        for (int i = 0; i < 16; i++) m[i] = pick_word(kind);
        // repeated row gives a zero determinant
        if ($urandom_range(9) == 0) begin
            for (int c = 0; c < 4; c++) m[12+c] = m[4+c];
        end
        send_matrix(m);
    endtask

    task automatic directed_matrices();
        logic [31:0] m [16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h3F80_0000 : 32'h0000_0000;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = 32'h0000_0000;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = 32'hFFFF_FFFF;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h7F80_0000 : 32'h8000_0000;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0000_0001 : 32'h0000_0000;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h7F7F_FFFF : 32'h0000_0000;
        send_matrix(m);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_matrices();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int k = 0; k < 13; k++) begin
                if (ph == 1 && k == 6) begin
                    i_valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                random_matrix();
            end
        end
        i_valid = 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("** matrix4_inverse_float: PASSED **");
        end else begin
            $display("** matrix4_inverse_float: FAILED **");
        end
        $finish;
    end

endmodule
